// ----- rtl/core/note_key_state_table_macros.svh -----
// Assertion macros used by the note key state table RTL.
`ifndef NOTE_KEY_STATE_TABLE_MACROS_SVH
`define NOTE_KEY_STATE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define NKST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("note key state table check failed");
`define NKST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("note key state table check failed");
`else
`define NKST_ASSERT_IMP(label, clk, rst, ante, cons)
`define NKST_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/ntks_pkg.sv -----
package ntks_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic signed [7:0]  transpose;
  } req_t;

  typedef struct packed {
    logic               is_pressed;
    logic [6:0]         stored_velocity;
    logic signed [7:0]  stored_transpose;
    logic [31:0]        press_duration;
    logic [7:0]         pressed_count;
  } rsp_t;

endpackage

// ----- rtl/core/note_key_state_table.sv -----
// Note key state table: one entry per key (pressed flag, velocity, transpose,
// time word) held in a synchronous RAM, plus a tick counter advanced by tick
// requests and a held-key count. Each request transaction returns exactly one
// response transaction. The accept cycle of a request issues the RAM read;
// the update state then updates the entry, writes it back and loads the
// response register. The next request is taken only once that update is done,
// so a new request is not accepted while one is in progress. A response
// waiting in the output register stalls only the update cycle of the
// following request. The table is clear right after reset through per-entry
// valid flags; there is no clearing pass.
`include "note_key_state_table_macros.svh"

module note_key_state_table
  import ntks_pkg::*;
#(
  parameter int NUM_NOTES = 128,
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(NUM_NOTES);
  localparam int EW = TIME_BITS + 16;
  localparam logic [7:0] NOTE_LIMIT = 8'(NUM_NOTES);

  state_t state, state_next;

  logic [TIME_BITS-1:0] tick_count, tick_count_next;
  logic [7:0]           held_count, held_count_next;
  logic [NUM_NOTES-1:0] valid;

  req_t    item;
  logic    item_in_range;
  logic    item_valid;

  logic          rsp_valid_next;
  rsp_t          rsp_next;

  logic          req_fire;
  logic          req_in_range;
  logic          update;
  logic          ram_we;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] cur;

  logic                 cur_pressed;
  logic [6:0]           cur_velocity;
  logic signed [7:0]    cur_transpose;
  logic [TIME_BITS-1:0] cur_time;
  logic [TIME_BITS-1:0] diff;

  logic                 new_pressed;
  logic [6:0]           new_velocity;
  logic signed [7:0]    new_transpose;
  logic [TIME_BITS-1:0] new_time;
  logic [TIME_BITS-1:0] dur;

  assign req_fire     = req_valid && req_ready;
  assign req_in_range = {1'b0, req.note} < NOTE_LIMIT;

  assign cur           = item_valid ? ram_rdata : '0;
  assign cur_pressed   = cur[EW-1];
  assign cur_velocity  = cur[TIME_BITS+14:TIME_BITS+8];
  assign cur_transpose = cur[TIME_BITS+7:TIME_BITS];
  assign cur_time      = cur[TIME_BITS-1:0];
  assign diff          = tick_count - cur_time;
  assign ram_wdata     = {new_pressed, new_velocity, new_transpose, new_time};

  ntks_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_NOTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item.note[AW-1:0]),
    .wdata (ram_wdata),
    .re    (req_fire),
    .raddr (req.note[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    tick_count_next = tick_count;
    held_count_next = held_count;
    rsp_valid_next  = rsp_valid;
    rsp_next        = rsp;
    req_ready       = 1'b0;
    update          = 1'b0;
    ram_we          = 1'b0;

    new_pressed   = cur_pressed;
    new_velocity  = cur_velocity;
    new_transpose = cur_transpose;
    new_time      = cur_time;
    dur           = cur_pressed ? diff : cur_time;

    unique case (item.operation)
      OP_ON: begin
        new_velocity  = item.velocity;
        new_transpose = item.transpose;
        if (!cur_pressed) begin
          new_pressed = 1'b1;
          new_time    = tick_count;
          dur         = '0;
        end
      end
      OP_OFF: begin
        new_velocity = item.velocity;
        if (cur_pressed) begin
          new_pressed = 1'b0;
          new_time    = diff;
          dur         = diff;
        end
      end
      OP_TICK, OP_QUERY: begin
      end
    endcase

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_UPDATE;
          if (req.operation == OP_TICK) begin
            tick_count_next = tick_count + 1'b1;
          end
        end
      end
      ST_UPDATE: begin
        if (!rsp_valid || rsp_ready) begin
          update         = 1'b1;
          state_next     = ST_IDLE;
          rsp_valid_next = 1'b1;
          if (item_in_range) begin
            ram_we = (item.operation == OP_ON) || (item.operation == OP_OFF);
            if (new_pressed && !cur_pressed) begin
              held_count_next = held_count + 1'b1;
            end else if (!new_pressed && cur_pressed) begin
              held_count_next = held_count - 1'b1;
            end
            rsp_next.is_pressed       = new_pressed;
            rsp_next.stored_velocity  = new_velocity;
            rsp_next.stored_transpose = new_transpose;
            rsp_next.press_duration   = 32'(dur);
          end else begin
            rsp_next.is_pressed       = 1'b0;
            rsp_next.stored_velocity  = '0;
            rsp_next.stored_transpose = '0;
            rsp_next.press_duration   = '0;
          end
          rsp_next.pressed_count = held_count_next;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      held_count <= '0;
      rsp_valid  <= 1'b0;
      valid      <= '0;
    end else begin
      state      <= state_next;
      tick_count <= tick_count_next;
      held_count <= held_count_next;
      rsp_valid  <= rsp_valid_next;
      if (ram_we) begin
        valid[item.note[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (req_fire) begin
      item          <= req;
      item_in_range <= req_in_range;
      item_valid    <= req_in_range && valid[req.note[AW-1:0]];
    end
  end

  `NKST_ASSERT_NXT(a_accept_then_update, clk, rst, req_fire, state == ST_UPDATE && !req_ready)
  `NKST_ASSERT_IMP(a_held_bound, clk, rst, 1'b1, held_count <= NOTE_LIMIT)
  `NKST_ASSERT_IMP(a_write_in_update, clk, rst, ram_we, update && item_in_range)
  `NKST_ASSERT_NXT(a_update_loads_rsp, clk, rst, update, rsp_valid && state == ST_IDLE)
  `NKST_ASSERT_IMP(a_held_step, clk, rst, held_count_next != held_count, update)

endmodule

// ----- rtl/core/ntks_ram.sv -----
module ntks_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
